>>> sv/egcd_pkg.sv
// egcd_pkg: shared types and constants for the extended gcd core
// used by egcd_div_unit, extended_gcd_bezout_core and egcd_checker
package egcd_pkg;

  localparam int unsigned DefaultWidth = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_NEXT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

>>> sv/extended_gcd_bezout_core.sv
// extended_gcd_bezout_core: gcd and bezout coefficients of two operands
// depends on egcd_pkg and egcd_div_unit
//
// channel  dir  handshake                  payload
// in       in   in_valid_i / in_stall_o    operand_a_i, operand_b_i
// out      out  out_valid_o / out_stall_i  coef_x_o, coef_y_o, gcd_value_o
//
// one word at a time; in_stall_o is high from acceptance until the result
// moves to the output register. each euclid step is one division in the
// one-bit-per-cycle divider; b = 0 goes straight to the result.
// a waiting result does not block the next word, only the one after it.
// asynchronous active-low reset clears the control state only.
module extended_gcd_bezout_core #(
  parameter int unsigned WIDTH = egcd_pkg::DefaultWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [WIDTH-1:0]   operand_a_i,
  input  logic [WIDTH-1:0]   operand_b_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [WIDTH:0]     coef_x_o,
  output logic [WIDTH:0]     coef_y_o,
  output logic [WIDTH-1:0]   gcd_value_o
);

  egcd_pkg::state_e state_q, state_d;

  logic [WIDTH-1:0] ra_q, ra_d, rb_q, rb_d;
  logic [WIDTH:0]   xa_q, xa_d, ya_q, ya_d, xb_q, xb_d, yb_q, yb_d;
  logic [WIDTH:0]   outx_q, outx_d, outy_q, outy_d;
  logic [WIDTH-1:0] outg_q, outg_d;
  logic             out_valid_q, out_valid_d;

  logic                  div_start;
  logic                  out_free;
  logic                  in_take;
  egcd_pkg::div_status_t div_status;
  logic [WIDTH-1:0]      div_rem;
  logic [WIDTH:0]        prod_x, prod_y;

  egcd_div_unit #(
    .WIDTH(WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ra_q),
    .divisor_i  (rb_q),
    .mul_x_i    (xb_q),
    .mul_y_i    (yb_q),
    .status_o   (div_status),
    .rem_o      (div_rem),
    .prod_x_o   (prod_x),
    .prod_y_o   (prod_y)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_take  = (state_q == egcd_pkg::ST_IDLE) && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      egcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (operand_b_i == '0) ? egcd_pkg::ST_FIN : egcd_pkg::ST_LOAD;
        end
      end
      egcd_pkg::ST_LOAD: begin
        state_d = egcd_pkg::ST_DIV;
      end
      egcd_pkg::ST_DIV: begin
        if (div_status.done) begin
          state_d = egcd_pkg::ST_NEXT;
        end
      end
      egcd_pkg::ST_NEXT: begin
        state_d = (div_rem == '0) ? egcd_pkg::ST_FIN : egcd_pkg::ST_LOAD;
      end
      egcd_pkg::ST_FIN: begin
        if (out_free) begin
          state_d = egcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = egcd_pkg::ST_IDLE;
      end
    endcase
  end

  // outputs and datapath
  always_comb begin
    ra_d        = ra_q;
    rb_d        = rb_q;
    xa_d        = xa_q;
    ya_d        = ya_q;
    xb_d        = xb_q;
    yb_d        = yb_q;
    outx_d      = outx_q;
    outy_d      = outy_q;
    outg_d      = outg_q;
    out_valid_d = out_valid_q && out_stall_i;
    div_start   = 1'b0;
    case (state_q)
      egcd_pkg::ST_IDLE: begin
        if (in_take) begin
          ra_d = operand_a_i;
          xa_d = (WIDTH + 1)'(1);
          ya_d = '0;
          if (operand_b_i == '0) begin
            rb_d = operand_a_i;
            xb_d = {{WIDTH{1'b0}}, (operand_a_i != '0)};
            yb_d = '0;
          end else begin
            rb_d = operand_b_i;
            xb_d = '0;
            yb_d = (WIDTH + 1)'(1);
          end
        end
      end
      egcd_pkg::ST_LOAD: begin
        div_start = 1'b1;
      end
      egcd_pkg::ST_NEXT: begin
        if (div_rem != '0) begin
          ra_d = rb_q;
          rb_d = div_rem;
          xa_d = xb_q;
          ya_d = yb_q;
          xb_d = xa_q - prod_x;
          yb_d = ya_q - prod_y;
        end
      end
      egcd_pkg::ST_FIN: begin
        if (out_free) begin
          outx_d      = xb_q;
          outy_d      = yb_q;
          outg_d      = rb_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= egcd_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ra_q   <= ra_d;
    rb_q   <= rb_d;
    xa_q   <= xa_d;
    ya_q   <= ya_d;
    xb_q   <= xb_d;
    yb_q   <= yb_d;
    outx_q <= outx_d;
    outy_q <= outy_d;
    outg_q <= outg_d;
  end

  assign in_stall_o  = (state_q != egcd_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign coef_x_o    = outx_q;
  assign coef_y_o    = outy_q;
  assign gcd_value_o = outg_q;

endmodule

>>> sv/egcd_div_unit.sv
// egcd_div_unit: restoring divider, one quotient bit per cycle, that also
// forms quotient * coefficient for both bezout coefficients by shift-add
// depends on egcd_pkg
module egcd_div_unit #(
  parameter int unsigned WIDTH = egcd_pkg::DefaultWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [WIDTH-1:0]    divisor_i,
  input  logic [WIDTH:0]      mul_x_i,
  input  logic [WIDTH:0]      mul_y_i,
  output egcd_pkg::div_status_t status_o,
  output logic [WIDTH-1:0]    rem_o,
  output logic [WIDTH:0]      prod_x_o,
  output logic [WIDTH:0]      prod_y_o
);

  localparam int unsigned CntW = $clog2(WIDTH);
  localparam logic [CntW-1:0] CntLast = CntW'(WIDTH - 1);

  logic [WIDTH-1:0] rem_q, rem_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH:0]   accx_q, accx_d;
  logic [WIDTH:0]   accy_q, accy_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem_q, quo_q[WIDTH-1]};
    diff    = shifted - {1'b0, divisor_i};
    ge      = shifted >= {1'b0, divisor_i};
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    accx_d = accx_q;
    accy_d = accy_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      accx_d = '0;
      accy_d = '0;
      cnt_d  = CntLast;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      quo_d  = {quo_q[WIDTH-2:0], ge};
      accx_d = {accx_q[WIDTH-1:0], 1'b0} + (ge ? mul_x_i : '0);
      accy_d = {accy_q[WIDTH-1:0], 1'b0} + (ge ? mul_y_i : '0);
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    accx_q <= accx_d;
    accy_q <= accy_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign rem_o         = rem_q;
  assign prod_x_o      = accx_q;
  assign prod_y_o      = accy_q;

endmodule

>>> sv/egcd_checker.sv
// egcd_checker: port-level checks on extended_gcd_bezout_core
// depends on egcd_pkg; bound to extended_gcd_bezout_core below
module egcd_checker #(
  parameter int unsigned WIDTH = egcd_pkg::DefaultWidth
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic [WIDTH-1:0] operand_a_i,
  input logic [WIDTH-1:0] operand_b_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic [WIDTH:0]   coef_x_o,
  input logic [WIDTH:0]   coef_y_o,
  input logic [WIDTH-1:0] gcd_value_o
);

  // a stalled input word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(operand_a_i)
      && $stable(operand_b_i))
    else $error("stalled input word changed");

  // a stalled result word is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(gcd_value_o)
      && $stable(coef_x_o) && $stable(coef_y_o))
    else $error("stalled result word changed");

  // busy after taking a word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // a new result only comes out of a busy block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared without work in progress");

  // zero gcd (both operands zero) comes with zero coefficients
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (gcd_value_o == '0) |-> (coef_x_o == '0) && (coef_y_o == '0))
    else $error("zero gcd with non-zero coefficients");

endmodule

bind extended_gcd_bezout_core egcd_checker #(
  .WIDTH(WIDTH)
) u_egcd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .operand_a_i (operand_a_i),
  .operand_b_i (operand_b_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .coef_x_o    (coef_x_o),
  .coef_y_o    (coef_y_o),
  .gcd_value_o (gcd_value_o)
);

>>> sim/egcd_checker.sv
`timescale 1ns / 100ps
// egcd_scoreboard: watches both channels of extended_gcd_bezout_core, predicts gcd and
// bezout coefficients of every accepted word and compares the result words in order
// depends on egcd_pkg for the default width
module egcd_scoreboard #(
  parameter int unsigned WIDTH = egcd_pkg::DefaultWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_stall_i,
  input  logic [WIDTH-1:0] operand_a_i,
  input  logic [WIDTH-1:0] operand_b_i,
  input  logic             out_valid_i,
  input  logic             out_stall_i,
  input  logic [WIDTH:0]   coef_x_i,
  input  logic [WIDTH:0]   coef_y_i,
  input  logic [WIDTH-1:0] gcd_value_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o
);

  typedef struct packed {
    logic [WIDTH:0]   coef_x;
    logic [WIDTH:0]   coef_y;
    logic [WIDTH-1:0] gcd_value;
  } bezout_t;

  bezout_t     bezout_q[$];
  int unsigned fails = 0;
  int unsigned waiting = 0;

  assign fail_count_o = fails;
  assign pending_o    = waiting;

  function automatic bezout_t solve_bezout(logic [WIDTH-1:0] a, logic [WIDTH-1:0] b);
    longint  rem_old, rem_new, quot, rest;
    longint  x_old, y_old, x_new, y_new, x_next, y_next;
    bezout_t res;
    if (b == '0) begin
      x_new   = (a != '0) ? 1 : 0;
      y_new   = 0;
      rem_new = longint'(a);
    end else begin
      rem_old = longint'(a);
      rem_new = longint'(b);
      x_old   = 1;
      y_old   = 0;
      x_new   = 0;
      y_new   = 1;
      quot    = rem_old / rem_new;
      rest    = rem_old % rem_new;
      while (rest != 0) begin
        x_next  = x_old - quot * x_new;
        y_next  = y_old - quot * y_new;
        x_old   = x_new;
        y_old   = y_new;
        x_new   = x_next;
        y_new   = y_next;
        rem_old = rem_new;
        rem_new = rest;
        quot    = rem_old / rem_new;
        rest    = rem_old % rem_new;
      end
    end
    res.coef_x    = x_new[WIDTH:0];
    res.coef_y    = y_new[WIDTH:0];
    res.gcd_value = rem_new[WIDTH-1:0];
    return res;
  endfunction

  always @(posedge clk_i) begin : watch
    bezout_t want;
    if (rst_ni) begin
      if (out_valid_i && !out_stall_i) begin
        if (bezout_q.size() == 0) begin
          $error("result word with no expectation waiting");
          fails++;
        end else begin
          want = bezout_q.pop_front();
          if (coef_x_i !== want.coef_x) begin
            $error("coef_x: expected %0d, got %0d", $signed(want.coef_x), $signed(coef_x_i));
            fails++;
          end
          if (coef_y_i !== want.coef_y) begin
            $error("coef_y: expected %0d, got %0d", $signed(want.coef_y), $signed(coef_y_i));
            fails++;
          end
          if (gcd_value_i !== want.gcd_value) begin
            $error("gcd_value: expected %0d, got %0d", want.gcd_value, gcd_value_i);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        bezout_q.push_back(solve_bezout(operand_a_i, operand_b_i));
      end
      waiting = bezout_q.size();
    end
  end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps
// tb_top: clock, reset and randomized stimulus for extended_gcd_bezout_core, with
// random stalls on the result side; checking is done by egcd_scoreboard
module tb_top;

  localparam int unsigned WIDTH       = egcd_pkg::DefaultWidth;
  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned RandomWords = 714;
  localparam int unsigned PressWords  = 16;
  localparam int unsigned HoldCycles  = 2500;
  localparam int unsigned CycleLimit  = 8_000_000;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [WIDTH-1:0] operand_a = '0;
  logic [WIDTH-1:0] operand_b = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [WIDTH:0]   coef_x;
  logic [WIDTH:0]   coef_y;
  logic [WIDTH-1:0] gcd_value;
  int unsigned      fail_count;
  int unsigned      pending;
  int unsigned      cycles = 0;
  bit               hold_req = 1'b0;
  bit               hold_taken = 1'b0;
  bit               gaps_on = 1'b1;

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  extended_gcd_bezout_core #(.WIDTH(WIDTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .operand_a_i (operand_a),
    .operand_b_i (operand_b),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .coef_x_o    (coef_x),
    .coef_y_o    (coef_y),
    .gcd_value_o (gcd_value)
  );

  egcd_scoreboard #(.WIDTH(WIDTH)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .operand_a_i  (operand_a),
    .operand_b_i  (operand_b),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .coef_x_i     (coef_x),
    .coef_y_i     (coef_y),
    .gcd_value_i  (gcd_value),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic int unsigned pick_open();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return $urandom_range(1, 4);
    if (roll < 90) return $urandom_range(5, 30);
    return $urandom_range(50, 300);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 75) return $urandom_range(1, 3);
    if (roll < 95) return $urandom_range(4, 20);
    return $urandom_range(30, 200);
  endfunction

  // result side: random stall runs, plus one long hold-off on request
  initial begin : receiver
    int unsigned open_len;
    int unsigned stall_len;
    @(posedge rst_ni);
    forever begin
      if (hold_req && !hold_taken) begin
        open_len  = 0;
        stall_len = HoldCycles;
        @(negedge clk_i);
        out_stall  <= 1'b1;
        hold_taken = 1'b1;
      end else begin
        open_len  = pick_open();
        stall_len = pick_stall();
      end
      repeat (open_len) begin
        @(negedge clk_i);
        out_stall <= 1'b0;
      end
      repeat (stall_len) begin
        @(negedge clk_i);
        out_stall <= 1'b1;
      end
    end
  end

  task automatic send_word(input logic [WIDTH-1:0] a, input logic [WIDTH-1:0] b);
    @(negedge clk_i);
    in_valid  <= 1'b1;
    operand_a <= a;
    operand_b <= b;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic sender_gap();
    int unsigned roll;
    int unsigned len;
    roll = $urandom_range(99);
    if (!gaps_on || roll < 45) len = 0;
    else if (roll < 80) len = $urandom_range(1, 3);
    else if (roll < 95) len = $urandom_range(4, 20);
    else len = $urandom_range(30, 150);
    if (len > 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (len - 1) @(negedge clk_i);
    end
  endtask

  task automatic pick_operands(output logic [WIDTH-1:0] a, output logic [WIDTH-1:0] b);
    int unsigned roll;
    int unsigned k;
    logic [WIDTH-1:0] fib_lo, fib_hi, fib_nx, g;
    roll = $urandom_range(99);
    if (roll < 40) begin
      a = $urandom();
      b = $urandom();
    end else if (roll < 60) begin
      a = $urandom_range(0, 255);
      b = $urandom_range(0, 255);
    end else if (roll < 75) begin
      g = $urandom_range(1, 65535);
      a = g * $urandom_range(0, 32'hFFFF_FFFF / g);
      b = g * $urandom_range(0, 32'hFFFF_FFFF / g);
    end else if (roll < 85) begin
      a = $urandom();
      b = '0;
      if ($urandom_range(1)) begin
        b = a;
        a = '0;
      end
    end else if (roll < 95) begin
      k = $urandom_range(2, 46);
      fib_lo = 1;
      fib_hi = 1;
      repeat (k - 1) begin
        fib_nx = fib_lo + fib_hi;
        fib_lo = fib_hi;
        fib_hi = fib_nx;
      end
      a = fib_hi;
      b = fib_lo;
      if ($urandom_range(1)) begin
        a = fib_lo;
        b = fib_hi;
      end
    end else begin
      a = '1 - $urandom_range(0, 3);
      b = $urandom_range(1) ? '1 : ('1 >> $urandom_range(1, WIDTH - 1));
    end
  endtask

  initial begin : stimulus
    logic [WIDTH-1:0] a;
    logic [WIDTH-1:0] b;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero operands, extremes, divisibility, worst-case step count
    send_word('0, '0);
    send_word('0, 32'd12345);
    send_word(32'd6789, '0);
    send_word('0, '1);
    send_word('1, '0);
    send_word('1, '1);
    send_word('1, '1 - 1);
    send_word('1 - 1, '1);
    send_word(32'd1, 32'd1);
    send_word(32'd1, '1);
    send_word('1, 32'd1);
    send_word(32'd240, 32'd46);
    send_word(32'd46, 32'd240);
    send_word(32'd1000, 32'd10);
    send_word(32'd7, 32'd700007);
    send_word(32'd2971215073, 32'd1836311903);
    send_word(32'd1836311903, 32'd2971215073);
    send_word(32'h8000_0000, 32'h4000_0000);
    send_word(32'h5555_5555, 32'hAAAA_AAAA);
    send_word(32'hAAAA_AAAA, 32'h5555_5555);
    send_word(32'hFFFF_FFFB, 32'hFFFF_FFF1);
    sender_gap();

    // fill the core while the result side holds off
    hold_req = 1'b1;
    wait (hold_taken);
    for (int i = 0; i < PressWords; i++) begin
      send_word($urandom_range(0, 255), $urandom_range(1, 255));
    end
    sender_gap();

    for (int i = 0; i < RandomWords; i++) begin
      gaps_on = ((i / 50) % 4) != 1;
      pick_operands(a, b);
      send_word(a, b);
      sender_gap();
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    do @(negedge clk_i); while (pending != 0);
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
